FILE: hdl/cmm_pkg.sv
// ----------------------------------------------------------------------------
// cmm_pkg
// Shared types, constants and helpers of the channel mixing matrix.
// ----------------------------------------------------------------------------
`default_nettype none

package cmm_pkg;

  localparam int MAX_CH    = 4;
  localparam int COEF_W    = 16;
  localparam int REG_W     = 64;
  localparam int ADDR_W    = 6;
  localparam int IDX_W     = 3;
  localparam int CODE_W    = 2;
  localparam int OUT_W     = 32;

  // Register indexes; byte address is eight times the index.
  localparam logic [IDX_W-1:0] REG_IN_CHAN  = 3'd0;
  localparam logic [IDX_W-1:0] REG_OUT_CHAN = 3'd1;
  localparam logic [IDX_W-1:0] REG_COEF0    = 3'd2;
  localparam logic [IDX_W-1:0] REG_COEF1    = 3'd3;
  localparam logic [IDX_W-1:0] REG_COEF2    = 3'd4;
  localparam logic [IDX_W-1:0] REG_COEF3    = 3'd5;

  // Channel count codes.
  localparam logic [CODE_W-1:0] CH_CODE_ONE = 2'd0;
  localparam logic [CODE_W-1:0] CH_CODE_TWO = 2'd1;

  typedef logic [MAX_CH-1:0][COEF_W-1:0] coef_row_t;

  typedef struct packed {
    logic [CODE_W-1:0]             in_code;
    logic [CODE_W-1:0]             out_code;
    coef_row_t [MAX_CH-1:0]        gain;
  } cfg_t;

  // Active-channel mask for a count code; codes two and above mean four channels.
  function automatic logic [MAX_CH-1:0] chan_mask(input logic [CODE_W-1:0] code);
    logic [MAX_CH-1:0] m;
    unique case (code)
      CH_CODE_ONE: m = 4'b0001;
      CH_CODE_TWO: m = 4'b0011;
      default:     m = 4'b1111;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/cmm_regs.sv
// ----------------------------------------------------------------------------
// cmm_regs
// Configuration register file behind an APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module cmm_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [cmm_pkg::ADDR_W-1:0] paddr,
  input  wire logic [cmm_pkg::REG_W-1:0]  pwdata,
  output logic      [cmm_pkg::REG_W-1:0]  prdata,
  output logic                            pready,
  output cmm_pkg::cfg_t                   cfg
);
  import cmm_pkg::*;

  logic [IDX_W-1:0] idx;
  logic             wr;

  assign idx    = paddr[ADDR_W-1:ADDR_W-IDX_W];
  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_IN_CHAN:  cfg.in_code  <= pwdata[CODE_W-1:0];
        REG_OUT_CHAN: cfg.out_code <= pwdata[CODE_W-1:0];
        REG_COEF0:    cfg.gain[0]  <= pwdata;
        REG_COEF1:    cfg.gain[1]  <= pwdata;
        REG_COEF2:    cfg.gain[2]  <= pwdata;
        REG_COEF3:    cfg.gain[3]  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_IN_CHAN:  prdata = REG_W'(cfg.in_code);
      REG_OUT_CHAN: prdata = REG_W'(cfg.out_code);
      REG_COEF0:    prdata = cfg.gain[0];
      REG_COEF1:    prdata = cfg.gain[1];
      REG_COEF2:    prdata = cfg.gain[2];
      REG_COEF3:    prdata = cfg.gain[3];
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/cmm_mac.sv
// ----------------------------------------------------------------------------
// cmm_mac
// Input capture, 4x4 product array and two-level adder tree.
// ----------------------------------------------------------------------------
`default_nettype none

module cmm_mac #(
  parameter int SAMPLE_WIDTH = 32
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  cmm_pkg::cfg_t                                cfg,
  input  wire logic                                    in_valid,
  input  wire logic signed [SAMPLE_WIDTH-1:0]          in_samp [cmm_pkg::MAX_CH],
  input  wire logic                                    in_last,
  output logic                                         sum_valid,
  output logic signed [SAMPLE_WIDTH+cmm_pkg::COEF_W+1:0] sum [cmm_pkg::MAX_CH],
  output logic                                         sum_last
);
  import cmm_pkg::*;

  localparam int PW = SAMPLE_WIDTH + COEF_W;
  localparam int AW = PW + 2;

  logic [MAX_CH-1:0] imask;

  logic                           s1_valid, s2_valid, s3_valid;
  logic                           s1_last, s2_last, s3_last;
  logic signed [SAMPLE_WIDTH-1:0] samp [MAX_CH];
  logic signed [PW-1:0]           prod [MAX_CH][MAX_CH];
  logic signed [PW:0]             pair_lo [MAX_CH];
  logic signed [PW:0]             pair_hi [MAX_CH];

  assign imask = chan_mask(cfg.in_code);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      sum_valid <= 1'b0;
    end else begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      sum_valid <= s3_valid;
    end
  end

  // Inactive input channels enter the tree as zero.
  always_ff @(posedge clk) begin
    s1_last <= in_last;
    for (int i = 0; i < MAX_CH; i++) begin
      samp[i] <= imask[i] ? in_samp[i] : '0;
    end
  end

  always_ff @(posedge clk) begin
    s2_last <= s1_last;
    for (int i = 0; i < MAX_CH; i++) begin
      for (int j = 0; j < MAX_CH; j++) begin
        prod[i][j] <= PW'(samp[i]) * PW'($signed(cfg.gain[i][j]));
      end
    end
  end

  always_ff @(posedge clk) begin
    s3_last <= s2_last;
    for (int j = 0; j < MAX_CH; j++) begin
      pair_lo[j] <= (PW+1)'(prod[0][j]) + (PW+1)'(prod[1][j]);
      pair_hi[j] <= (PW+1)'(prod[2][j]) + (PW+1)'(prod[3][j]);
    end
  end

  always_ff @(posedge clk) begin
    sum_last <= s3_last;
    for (int j = 0; j < MAX_CH; j++) begin
      sum[j] <= AW'(pair_lo[j]) + AW'(pair_hi[j]);
    end
  end

endmodule

`default_nettype wire

FILE: hdl/cmm_sat.sv
// ----------------------------------------------------------------------------
// cmm_sat
// Scaling with truncation toward zero, saturation and output channel masking.
// ----------------------------------------------------------------------------
`default_nettype none

module cmm_sat #(
  parameter int SAMPLE_WIDTH   = 32,
  parameter int COEF_FRAC_BITS = 12
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst,
  input  cmm_pkg::cfg_t                                      cfg,
  input  wire logic                                          sum_valid,
  input  wire logic signed [SAMPLE_WIDTH+cmm_pkg::COEF_W+1:0] sum [cmm_pkg::MAX_CH],
  input  wire logic                                          sum_last,
  output logic                                               done,
  output logic        [cmm_pkg::OUT_W-1:0]                   res [cmm_pkg::MAX_CH],
  output logic                                               res_last
);
  import cmm_pkg::*;

  localparam int AW = SAMPLE_WIDTH + COEF_W + 2;
  localparam int QW = AW - COEF_FRAC_BITS;

  localparam logic signed [QW-1:0] QMAX =
    {{(QW-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [QW-1:0] QMIN =
    {{(QW-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

  logic [MAX_CH-1:0]        omask;
  logic                     q_valid, q_last;
  logic signed [QW-1:0]     quot [MAX_CH];
  logic        [AW-1:0]     biased [MAX_CH];
  logic signed [SAMPLE_WIDTH-1:0] sat [MAX_CH];

  assign omask = chan_mask(cfg.out_code);

  // A negative sum gets 2^F-1 added before the shift, so it rounds toward zero.
  always_comb begin
    for (int j = 0; j < MAX_CH; j++) begin
      biased[j] = sum[j] + {{(AW-COEF_FRAC_BITS){1'b0}}, {COEF_FRAC_BITS{sum[j][AW-1]}}};
    end
  end

  always_comb begin
    for (int j = 0; j < MAX_CH; j++) begin
      if (quot[j] > QMAX) begin
        sat[j] = QMAX[SAMPLE_WIDTH-1:0];
      end else if (quot[j] < QMIN) begin
        sat[j] = QMIN[SAMPLE_WIDTH-1:0];
      end else begin
        sat[j] = quot[j][SAMPLE_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
      done    <= 1'b0;
    end else begin
      q_valid <= sum_valid;
      done    <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    q_last   <= sum_last;
    res_last <= q_last;
    for (int j = 0; j < MAX_CH; j++) begin
      quot[j] <= biased[j][AW-1:COEF_FRAC_BITS];
      res[j]  <= omask[j] ? OUT_W'(sat[j]) : '0;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/channel_mix_matrix.sv
// ----------------------------------------------------------------------------
// channel_mix_matrix
// 4x4 audio mixing matrix with Q4.12 gains and saturating outputs.
// ----------------------------------------------------------------------------
// Each frame passes through six register stages (capture, multiply, two adder
// levels, scale, saturate) before done rises.
// Throughput: one frame per cycle; busy is never asserted, and the result
// register takes a new frame every cycle since the receiver never stalls.
// Reset clears the configuration registers and the pipeline valid bits.
`default_nettype none

module channel_mix_matrix #(
  parameter int SAMPLE_WIDTH   = 32,
  parameter int COEF_FRAC_BITS = 12
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [cmm_pkg::ADDR_W-1:0] paddr,
  input  wire logic [cmm_pkg::REG_W-1:0]  pwdata,
  output logic      [cmm_pkg::REG_W-1:0]  prdata,
  output logic                            pready,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic signed [31:0]         in_ch0,
  input  wire logic signed [31:0]         in_ch1,
  input  wire logic signed [31:0]         in_ch2,
  input  wire logic signed [31:0]         in_ch3,
  input  wire logic                       block_end,
  output logic                            done,
  output logic signed [31:0]              out_ch0,
  output logic signed [31:0]              out_ch1,
  output logic signed [31:0]              out_ch2,
  output logic signed [31:0]              out_ch3,
  output logic                            block_end_out
);
  import cmm_pkg::*;

  localparam int AW = SAMPLE_WIDTH + COEF_W + 2;

  cfg_t                           cfg;
  logic                           accept;
  logic signed [SAMPLE_WIDTH-1:0] in_samp [MAX_CH];
  logic                           sum_valid, sum_last;
  logic signed [AW-1:0]           sum [MAX_CH];
  logic        [OUT_W-1:0]        res [MAX_CH];

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Only the low SAMPLE_WIDTH bits of each sample are significant.
  assign in_samp[0] = in_ch0[SAMPLE_WIDTH-1:0];
  assign in_samp[1] = in_ch1[SAMPLE_WIDTH-1:0];
  assign in_samp[2] = in_ch2[SAMPLE_WIDTH-1:0];
  assign in_samp[3] = in_ch3[SAMPLE_WIDTH-1:0];

  cmm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cmm_mac #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (accept),
    .in_samp   (in_samp),
    .in_last   (block_end),
    .sum_valid (sum_valid),
    .sum       (sum),
    .sum_last  (sum_last)
  );

  cmm_sat #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_sat (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .sum_valid (sum_valid),
    .sum       (sum),
    .sum_last  (sum_last),
    .done      (done),
    .res       (res),
    .res_last  (block_end_out)
  );

  assign out_ch0 = res[0];
  assign out_ch1 = res[1];
  assign out_ch2 = res[2];
  assign out_ch3 = res[3];

endmodule

`default_nettype wire

FILE: sim/channel_mix_matrix_tb.sv
// ----------------------------------------------------------------------------
// channel_mix_matrix_tb
// Self-checking bench for the 4x4 channel mixing matrix. Register settings
// are loaded over the APB port while the block is idle. Frames are then
// streamed with random sender gaps, and every result beat is compared with a
// mixing predictor kept inside the bench.
// ----------------------------------------------------------------------------
module channel_mix_matrix_tb;
  import cmm_pkg::*;

  localparam int SAMPLE_W  = 32;
  localparam int FRAC_BITS = 12;
  localparam int DRAIN_CYC = 10;

  typedef struct packed {
    logic [MAX_CH-1:0][31:0] smp;
    logic                    last;
  } frame_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [REG_W-1:0]  pwdata = '0;
  logic [REG_W-1:0]  prdata;
  logic              pready;
  logic              start = 1'b0;
  logic              busy;
  logic [31:0]       in_ch0 = '0;
  logic [31:0]       in_ch1 = '0;
  logic [31:0]       in_ch2 = '0;
  logic [31:0]       in_ch3 = '0;
  logic              block_end = 1'b0;
  logic              done;
  logic [31:0]       out_ch0;
  logic [31:0]       out_ch1;
  logic [31:0]       out_ch2;
  logic [31:0]       out_ch3;
  logic              block_end_out;

  channel_mix_matrix #(
    .SAMPLE_WIDTH  (SAMPLE_W),
    .COEF_FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .start        (start),
    .busy         (busy),
    .in_ch0       (in_ch0),
    .in_ch1       (in_ch1),
    .in_ch2       (in_ch2),
    .in_ch3       (in_ch3),
    .block_end    (block_end),
    .done         (done),
    .out_ch0      (out_ch0),
    .out_ch1      (out_ch1),
    .out_ch2      (out_ch2),
    .out_ch3      (out_ch3),
    .block_end_out(block_end_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bench copy of the register file.
  logic [CODE_W-1:0] in_code = '0;
  logic [CODE_W-1:0] out_code = '0;
  logic [REG_W-1:0]  coef_row [MAX_CH];

  frame_t frame_q [$];
  frame_t mix_q [$];
  frame_t next_frame;
  int     idle_pct = 0;
  logic   beat_taken = 1'b0;
  int     n_mixed = 0;
  int     n_mismatch = 0;
  int     n_settings = 0;

  function automatic int chan_cnt(logic [CODE_W-1:0] code);
    case (code)
      CH_CODE_ONE: return 1;
      CH_CODE_TWO: return 2;
      default:     return 4;
    endcase
  endfunction

  function automatic frame_t mix_frame(frame_t f);
    frame_t r;
    longint samp [MAX_CH];
    longint acc, q, smax, smin;
    int     ni, no;
    smax = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    smin = -smax - 1;
    ni = chan_cnt(in_code);
    no = chan_cnt(out_code);
    for (int i = 0; i < MAX_CH; i++)
      samp[i] = longint'($signed(f.smp[i] << (32 - SAMPLE_W))) >>> (32 - SAMPLE_W);
    for (int j = 0; j < MAX_CH; j++) begin
      acc = 0;
      q = 0;
      if (j < no) begin
        for (int i = 0; i < ni; i++)
          acc += samp[i] * longint'($signed(coef_row[i][16*j +: 16]));
        // Scaling truncates toward zero, so negative sums shift their magnitude.
        if (acc < 0) q = -((-acc) >>> FRAC_BITS);
        else q = acc >>> FRAC_BITS;
        if (q > smax) q = smax;
        if (q < smin) q = smin;
      end
      r.smp[j] = q[31:0];
    end
    r.last = f.last;
    return r;
  endfunction

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 9))
      6, 7:    return 32'($urandom_range(0, 65535)) - 32'd32768;
      8:       return 32'h7FFF_FFFF;
      9:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic frame_t rand_frame();
    frame_t f;
    for (int i = 0; i < MAX_CH; i++) f.smp[i] = rand_sample();
    f.last = 1'($urandom_range(0, 1));
    return f;
  endfunction

  function automatic logic [REG_W-1:0] rand_row();
    logic [REG_W-1:0] row;
    for (int j = 0; j < MAX_CH; j++) begin
      case ($urandom_range(0, 9))
        4, 5, 6: row[16*j +: 16] = 16'($urandom_range(0, 16383)) - 16'd8192;
        7:       row[16*j +: 16] = 16'h1000;
        8:       row[16*j +: 16] = 16'h7FFF;
        9:       row[16*j +: 16] = 16'h8000;
        default: row[16*j +: 16] = 16'($urandom);
      endcase
    end
    return row;
  endfunction

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_IN_CHAN:  in_code = val[CODE_W-1:0];
      REG_OUT_CHAN: out_code = val[CODE_W-1:0];
      REG_COEF0:    coef_row[0] = val;
      REG_COEF1:    coef_row[1] = val;
      REG_COEF2:    coef_row[2] = val;
      REG_COEF3:    coef_row[3] = val;
      default:      ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_setting(logic [1:0] ic, logic [1:0] oc,
                              logic [REG_W-1:0] r0, logic [REG_W-1:0] r1,
                              logic [REG_W-1:0] r2, logic [REG_W-1:0] r3);
    // Random upper bits on the count register must be ignored.
    write_reg(REG_IN_CHAN, {$urandom, $urandom} & ~64'h3 | 64'(ic));
    write_reg(REG_OUT_CHAN, 64'(oc));
    write_reg(REG_COEF0, r0);
    write_reg(REG_COEF1, r1);
    write_reg(REG_COEF2, r2);
    write_reg(REG_COEF3, r3);
    n_settings++;
  endtask

  task automatic add_frame(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                           logic [31:0] d, logic last);
    frame_t f;
    f.smp[0] = a;
    f.smp[1] = b;
    f.smp[2] = c;
    f.smp[3] = d;
    f.last = last;
    frame_q.push_back(f);
  endtask

  // Blocks until every queued frame is sent and its result has come back.
  task automatic drain();
    while (frame_q.size() != 0 || mix_q.size() != 0 || start) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  // Driver: a frame stays on the pins until the beat is taken.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || beat_taken) begin
      if (frame_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        next_frame = frame_q.pop_front();
        in_ch0    <= next_frame.smp[0];
        in_ch1    <= next_frame.smp[1];
        in_ch2    <= next_frame.smp[2];
        in_ch3    <= next_frame.smp[3];
        block_end <= next_frame.last;
        start     <= 1'b1;
      end else begin
        in_ch0    <= $urandom;
        in_ch1    <= $urandom;
        in_ch2    <= $urandom;
        in_ch3    <= $urandom;
        block_end <= 1'($urandom_range(0, 1));
        start     <= 1'b0;
      end
    end
  end

  // Monitor: predicts on each accepted beat and checks each result beat.
  always @(posedge clk) begin
    frame_t sent, got, want;
    beat_taken = !rst && start && !busy;
    if (beat_taken) begin
      sent.smp[0] = in_ch0;
      sent.smp[1] = in_ch1;
      sent.smp[2] = in_ch2;
      sent.smp[3] = in_ch3;
      sent.last = block_end;
      mix_q.push_back(mix_frame(sent));
    end
    if (!rst && done) begin
      got.smp[0] = out_ch0;
      got.smp[1] = out_ch1;
      got.smp[2] = out_ch2;
      got.smp[3] = out_ch3;
      got.last = block_end_out;
      if (mix_q.size() == 0) begin
        $display("%0t: result beat with no frame outstanding, out_ch0=%0d",
                 $time, $signed(out_ch0));
        n_mismatch++;
      end else begin
        want = mix_q.pop_front();
        n_mixed++;
        for (int j = 0; j < MAX_CH; j++) begin
          if (got.smp[j] !== want.smp[j]) begin
            $display("%0t: out_ch%0d expected %0d got %0d", $time, j,
                     $signed(want.smp[j]), $signed(got.smp[j]));
            n_mismatch++;
          end
        end
        if (got.last !== want.last) begin
          $display("%0t: block_end_out expected %0b got %0b", $time,
                   want.last, got.last);
          n_mismatch++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < MAX_CH; i++) coef_row[i] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Full matrix with gain extremes: saturation both ways, unity gain and
    // truncation of small negative products toward zero.
    idle_pct = 0;
    load_setting(2'd2, 2'd2, {4{16'h7FFF}}, {4{16'h8000}}, {4{16'h1000}},
                 {16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF});
    add_frame(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    add_frame(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
    add_frame(32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
    add_frame(32'd1, -32'sd1, 32'd1, -32'sd1, 1'b1);
    add_frame(-32'sd1, -32'sd1, -32'sd1, -32'sd1, 1'b0);
    add_frame(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, -32'sd1, 1'b1);
    add_frame(32'h8000_0000, 32'h7FFF_FFFF, -32'sd1, 32'd0, 1'b0);
    add_frame(32'd4096, -32'sd4096, 32'd4095, -32'sd4095, 1'b1);
    add_frame(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF, 32'hFFFF_0000, 1'b0);
    drain();

    // One input, two outputs: channels one to three must not enter the sums.
    load_setting(2'd0, 2'd1, {16'h8000, 16'h7FFF, 16'hF000, 16'h1000},
                 {4{16'h7FFF}}, {4{16'h8000}}, {4{16'h4000}});
    add_frame(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 1'b1);
    add_frame(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hDEAD_BEEF, 1'b0);
    add_frame(-32'sd4097, 32'd77, -32'sd3, 32'd9, 1'b1);
    add_frame(32'd12345, -32'sd1, 32'd1, 32'h8000_0000, 1'b0);
    drain();

    // Two inputs, one output.
    load_setting(2'd1, 2'd0, {4{16'h0800}}, {16'h1000, 16'h2000, 16'h3000, 16'h8001},
                 {4{16'hFFFF}}, {4{16'h7FFF}});
    add_frame(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    add_frame(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
    add_frame(-32'sd8191, 32'd3, 32'd5, 32'd7, 1'b0);
    add_frame(32'd8191, -32'sd3, 32'd0, 32'd0, 1'b1);
    drain();

    // Code three on both sides counts as four channels.
    load_setting(2'd3, 2'd3, {16'h1000, 16'h0000, 16'h0000, 16'hF000},
                 {16'h0000, 16'h1000, 16'hF000, 16'h0000},
                 {16'h0000, 16'hF000, 16'h1000, 16'h0000},
                 {16'hF000, 16'h0000, 16'h0000, 16'h1000});
    add_frame(32'd1, 32'd2, 32'd3, 32'd4, 1'b0);
    add_frame(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    add_frame(-32'sd100, 32'd200, -32'sd300, 32'd400, 1'b0);
    add_frame(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    drain();

    // Random settings and frames, sender gaps rotating through the phases.
    for (int p = 0; p < 8; p++) begin
      case (p % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 52;
        default: idle_pct = 32;
      endcase
      load_setting(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                   rand_row(), rand_row(), rand_row(), rand_row());
      for (int k = 0; k < 50; k++) frame_q.push_back(rand_frame());
      drain();
    end

    $display("Checked %0d mixed frames over %0d register settings, channel codes 0 to 3,",
             n_mixed, n_settings);
    $display("with sender gaps of 0, 32 and 52 percent.");
    if (n_mismatch == 0 && mix_q.size() == 0) begin
      $display("** channel_mix_matrix: PASSED **");
    end else begin
      $display("** channel_mix_matrix: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d frames still waiting for results.", mix_q.size());
    $display("** channel_mix_matrix: FAILED **");
    $finish;
  end

endmodule
